>>> design/cswt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswt_pkg: shared types and constants of the cpu schedule wait time calculator
// field widths, saturation limits, parameter defaults and register indexes
// ----------------------------------------------------------------------------
package cswt_pkg;

    localparam int MAX_PROCS_DEF   = 16;
    localparam int BURST_WIDTH_DEF = 16;

    localparam int IN_DATA_W   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int QUANT_W     = 16;
    localparam int IDX_OUT_W   = 4;
    localparam int TIME_W      = 21;
    localparam int AVG_W       = 29;
    localparam int AVG_FRAC    = 8;
    localparam int OUT_DATA_W  = 104;
    localparam int MAX_RESULTS = 16;

    localparam logic [TIME_W-1:0]  TIME_MAX      = 21'h1FFFFF;
    localparam logic [AVG_W-1:0]   AVG_MAX       = 29'h1FFFFFFF;
    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd10;

    // scheduling policy
    localparam logic MODE_FCFS = 1'b0;
    localparam logic MODE_RR   = 1'b1;

    typedef enum logic [0:0] {
        CFG_SCHED_MODE   = 1'b0,
        CFG_TIME_QUANTUM = 1'b1
    } cfg_index_t;

endpackage

>>> design/cswt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswt_div: iterative unsigned divider
// restoring division, one quotient bit per cycle, done pulses when finished
// ----------------------------------------------------------------------------
module cswt_div #(
    parameter int DVD_W = 34,
    parameter int DVS_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                quo_reg  <= {quo_reg[DVD_W-2:0], fits};
                rem_reg  <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/cpu_schedule_wait_time_calculator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_schedule_wait_time_calculator: fcfs / round robin waiting time engine
// loads a batch of burst times, walks the schedule, reports per process times
// ----------------------------------------------------------------------------
// Bursts are loaded one request per cycle on the slave stream until a request
// with tlast; loads beyond MAX_PROCS are dropped and flagged in tuser of every
// result of that batch. The block then stops taking requests while a small
// sequencer walks the schedule through one shared time adder: each slice
// steps through read, run and advance/context switch states, and each finished
// process visited in round robin is stepped over in the read state. Totals take
// a read and an accumulate step per loaded process, the two averages come from
// one shared bit-serial divider, and results go out one at a time, each read,
// loaded and held in an output register until taken. The last result carries
// tlast and both averages in 8 fraction bit fixed point; the block is ready for
// the next batch once that result is taken.
// ----------------------------------------------------------------------------
module cpu_schedule_wait_time_calculator #(
    parameter int MAX_PROCS   = cswt_pkg::MAX_PROCS_DEF,
    parameter int BURST_WIDTH = cswt_pkg::BURST_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  cswt_pkg::cfg_index_t                cfg_index,
    input  logic [cswt_pkg::CFG_DATA_W-1:0]     cfg_data,
    // burst stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cswt_pkg::IN_DATA_W-1:0]      s_tdata,    // burst_time[15:0]
    input  logic                                s_tlast,    // last_item
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // proc_index[3:0], wait_ticks[24:4], turnaround_ticks[45:25],
    // avg_wait_q8[74:46], avg_turnaround_q8[103:75]
    output logic [cswt_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [0:0]                          m_tuser,    // overflowed
    output logic                                m_tlast     // last_result
);

    import cswt_pkg::*;

    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CLK_W = BURST_WIDTH + CNT_W + 1;
    localparam int TOT_W = TIME_W + CNT_W;
    localparam int DVD_W = TOT_W + AVG_FRAC;
    localparam int QW    = (BURST_WIDTH > QUANT_W) ? BURST_WIDTH : QUANT_W;
    localparam int WW    = (BURST_WIDTH > TIME_W) ? BURST_WIDTH : TIME_W;
    localparam int BIN_W = (BURST_WIDTH < IN_DATA_W) ? BURST_WIDTH : IN_DATA_W;

    typedef enum logic [3:0] {
        S_LOAD,
        S_ISSUE,
        S_EXEC,
        S_NEXT,
        S_TISSUE,
        S_TACC,
        S_DW_GO,
        S_DW_WAIT,
        S_DT_GO,
        S_DT_WAIT,
        S_EISSUE,
        S_ELOAD,
        S_EWAIT
    } state_t;

    // configuration registers
    logic               mode_reg;
    logic [QUANT_W-1:0] quantum_reg;

    // sequencer state
    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       left_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [MAX_PROCS-1:0]   done_reg;
    logic                   fin_reg;
    logic                   drop_reg;
    logic [CLK_W-1:0]       clock_reg;
    logic [TOT_W-1:0]       wait_tot_reg;
    logic [TOT_W-1:0]       ta_tot_reg;
    logic [AVG_W-1:0]       avg_wait_reg;
    logic [AVG_W-1:0]       avg_ta_reg;

    // output register
    logic                   m_valid_reg;
    logic [OUT_DATA_W-1:0]  m_data_reg;
    logic                   m_user_reg;
    logic                   m_last_reg;

    // burst stores
    logic [BURST_WIDTH-1:0] orig_mem [MAX_PROCS];
    logic [BURST_WIDTH-1:0] rem_mem  [MAX_PROCS];
    logic [TIME_W-1:0]      comp_mem [MAX_PROCS];
    logic [BURST_WIDTH-1:0] orig_rd_reg;
    logic [BURST_WIDTH-1:0] rem_rd_reg;
    logic [TIME_W-1:0]      comp_rd_reg;

    // datapath
    logic                   in_req;
    logic                   has_room;
    logic [BURST_WIDTH-1:0] burst_in;
    logic [QUANT_W-1:0]     q_eff;
    logic [QW-1:0]          rem_ext;
    logic [QW-1:0]          q_ext;
    logic [QW-1:0]          rem_left;
    logic                   run_fin;
    logic [CLK_W-1:0]       addend;
    logic [CLK_W-1:0]       clk_sum;
    logic [TIME_W-1:0]      comp_sat;
    logic [WW-1:0]          c_x;
    logic [WW-1:0]          o_x;
    logic [TIME_W-1:0]      wait_val;
    logic [CNT_W-1:0]       nres;
    logic                   emit_last;
    logic                   idx_wrap;
    logic [IDX_W-1:0]       idx_adv;
    logic                   orig_we;
    logic                   rem_we;
    logic [IDX_W-1:0]       rem_addr;
    logic [BURST_WIDTH-1:0] rem_wdata;
    logic                   comp_we;

    // divider
    logic                   div_start;
    logic                   div_done;
    logic [DVD_W-1:0]       div_dividend;
    logic [DVD_W-1:0]       div_quotient;
    logic [AVG_W-1:0]       avg_sat;

    // ------------------------------------------------------------------------
    // configuration, always accepted
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RR;
            quantum_reg <= QUANTUM_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCHED_MODE:   mode_reg    <= cfg_data[0];
                CFG_TIME_QUANTUM: quantum_reg <= cfg_data[QUANT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // combinational datapath
    // ------------------------------------------------------------------------
    assign s_tready = (state_reg == S_LOAD);
    assign in_req   = s_tvalid && s_tready;
    assign has_room = 32'(cnt_reg) < MAX_PROCS;
    assign burst_in = BURST_WIDTH'(s_tdata[BIN_W-1:0]);

    // zero quantum runs as one tick
    assign q_eff    = (quantum_reg == '0) ? QUANT_W'(1) : quantum_reg;
    assign rem_ext  = QW'(rem_rd_reg);
    assign q_ext    = QW'(q_eff);
    assign rem_left = rem_ext - q_ext;
    // fcfs always runs a process to completion
    assign run_fin  = (mode_reg == MODE_FCFS) || (rem_ext <= q_ext);

    // shared time adder: slice length while running, one tick for a switch
    always_comb
    begin
        if (state_reg == S_EXEC)
        begin
            addend = run_fin ? CLK_W'(rem_rd_reg) : CLK_W'(q_eff);
        end
        else
        begin
            addend = CLK_W'(1);
        end
    end
    assign clk_sum  = clock_reg + addend;
    assign comp_sat = (64'(clock_reg) > 64'(TIME_MAX)) ? TIME_MAX : TIME_W'(clock_reg);

    assign c_x      = WW'(comp_rd_reg);
    assign o_x      = WW'(orig_rd_reg);
    assign wait_val = (c_x >= o_x) ? TIME_W'(c_x - o_x) : '0;

    assign nres      = (32'(cnt_reg) < MAX_RESULTS) ? cnt_reg : CNT_W'(MAX_RESULTS);
    assign emit_last = CNT_W'(idx_reg) == (nres - CNT_W'(1));
    assign idx_wrap  = CNT_W'(idx_reg) == (cnt_reg - CNT_W'(1));
    assign idx_adv   = idx_wrap ? '0 : idx_reg + IDX_W'(1);

    // ------------------------------------------------------------------------
    // burst stores, one write and one registered read each
    // ------------------------------------------------------------------------
    assign orig_we   = in_req && has_room;
    assign rem_we    = orig_we || ((state_reg == S_EXEC) && !run_fin);
    assign rem_addr  = (state_reg == S_LOAD) ? cnt_reg[IDX_W-1:0] : idx_reg;
    assign rem_wdata = (state_reg == S_LOAD) ? burst_in : BURST_WIDTH'(rem_left);
    assign comp_we   = (state_reg == S_NEXT) && fin_reg;

    always_ff @(posedge clk)
    begin
        if (orig_we)
        begin
            orig_mem[cnt_reg[IDX_W-1:0]] <= burst_in;
        end
        orig_rd_reg <= orig_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[rem_addr] <= rem_wdata;
        end
        rem_rd_reg <= rem_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (comp_we)
        begin
            comp_mem[idx_reg] <= comp_sat;
        end
        comp_rd_reg <= comp_mem[idx_reg];
    end

    // ------------------------------------------------------------------------
    // averages through the shared divider
    // ------------------------------------------------------------------------
    assign div_start    = (state_reg == S_DW_GO) || (state_reg == S_DT_GO);
    assign div_dividend = (state_reg == S_DW_GO) ? {wait_tot_reg, AVG_FRAC'(0)}
                                                 : {ta_tot_reg, AVG_FRAC'(0)};
    assign avg_sat      = (div_quotient > DVD_W'(AVG_MAX)) ? AVG_MAX
                                                           : AVG_W'(div_quotient);

    cswt_div #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            cnt_reg      <= '0;
            left_reg     <= '0;
            idx_reg      <= '0;
            done_reg     <= '0;
            fin_reg      <= 1'b0;
            drop_reg     <= 1'b0;
            clock_reg    <= '0;
            wait_tot_reg <= '0;
            ta_tot_reg   <= '0;
            avg_wait_reg <= '0;
            avg_ta_reg   <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
            m_user_reg   <= 1'b0;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (in_req)
                    begin
                        if (has_room)
                        begin
                            cnt_reg  <= cnt_reg + CNT_W'(1);
                            left_reg <= cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                            left_reg <= cnt_reg;
                        end
                        if (s_tlast)
                        begin
                            idx_reg      <= '0;
                            done_reg     <= '0;
                            clock_reg    <= '0;
                            wait_tot_reg <= '0;
                            ta_tot_reg   <= '0;
                            state_reg    <= S_ISSUE;
                        end
                    end
                end

                // finished entries are stepped over
                S_ISSUE:
                begin
                    if (done_reg[idx_reg])
                    begin
                        idx_reg <= idx_adv;
                    end
                    else
                    begin
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    clock_reg <= clk_sum;
                    fin_reg   <= run_fin;
                    if (run_fin)
                    begin
                        done_reg[idx_reg] <= 1'b1;
                        left_reg          <= left_reg - CNT_W'(1);
                    end
                    state_reg <= S_NEXT;
                end

                // completion is written here; round robin adds the switch tick
                S_NEXT:
                begin
                    if (mode_reg == MODE_RR)
                    begin
                        clock_reg <= clk_sum;
                    end
                    if (left_reg == '0)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_TISSUE;
                    end
                    else
                    begin
                        idx_reg   <= idx_adv;
                        state_reg <= S_ISSUE;
                    end
                end

                S_TISSUE:
                begin
                    state_reg <= S_TACC;
                end

                S_TACC:
                begin
                    wait_tot_reg <= wait_tot_reg + TOT_W'(wait_val);
                    ta_tot_reg   <= ta_tot_reg + TOT_W'(comp_rd_reg);
                    if (idx_wrap)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_DW_GO;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_TISSUE;
                    end
                end

                S_DW_GO:
                begin
                    state_reg <= S_DW_WAIT;
                end

                S_DW_WAIT:
                begin
                    if (div_done)
                    begin
                        avg_wait_reg <= avg_sat;
                        state_reg    <= S_DT_GO;
                    end
                end

                S_DT_GO:
                begin
                    state_reg <= S_DT_WAIT;
                end

                S_DT_WAIT:
                begin
                    if (div_done)
                    begin
                        avg_ta_reg <= avg_sat;
                        state_reg  <= S_EISSUE;
                    end
                end

                S_EISSUE:
                begin
                    state_reg <= S_ELOAD;
                end

                S_ELOAD:
                begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= {emit_last ? avg_ta_reg : AVG_W'(0),
                                    emit_last ? avg_wait_reg : AVG_W'(0),
                                    comp_rd_reg,
                                    wait_val,
                                    IDX_OUT_W'(idx_reg)};
                    m_user_reg  <= drop_reg;
                    m_last_reg  <= emit_last;
                    state_reg   <= S_EWAIT;
                end

                S_EWAIT:
                begin
                    if (m_tready)
                    begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg)
                        begin
                            cnt_reg      <= '0;
                            left_reg     <= '0;
                            idx_reg      <= '0;
                            drop_reg     <= 1'b0;
                            clock_reg    <= '0;
                            wait_tot_reg <= '0;
                            ta_tot_reg   <= '0;
                            state_reg    <= S_LOAD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= S_EISSUE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;
    assign m_tlast    = m_last_reg;

endmodule
